### rtl/jdd_pkg.sv
// Shared types and constants for the joystick direction detector.
// No dependencies; used by every module of the block.

package jdd_pkg;

    localparam int QFrac     = 14;
    localparam int DivSteps  = QFrac;
    localparam int CntW      = $clog2(DivSteps);
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam logic [15:0] QOne = 16'sd16384;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_STICK_MIN      = 3'd0,
        REG_STICK_MAX      = 3'd1,
        REG_STICK_CENTER   = 3'd2,
        REG_DEAD_BAND      = 3'd3,
        REG_TRIGGER_LEVEL  = 3'd4,
        REG_RELEASE_LEVEL  = 3'd5,
        REG_HOLD_REPEAT_MS = 3'd6
    } cfg_reg_t;

    localparam logic [15:0] RstStickMin    = 16'd200;
    localparam logic [15:0] RstStickMax    = 16'd26000;
    localparam logic [15:0] RstStickCenter = 16'd13100;
    localparam logic [14:0] RstDeadBand    = 15'd2000;
    localparam logic [14:0] RstTrigger     = 15'd14746;
    localparam logic [14:0] RstRelease     = 15'd6554;
    localparam logic [15:0] RstHoldRepeat  = 16'd500;

    // Direction slots in the hysteresis state.
    localparam int DirUp    = 0;
    localparam int DirDown  = 1;
    localparam int DirLeft  = 2;
    localparam int DirRight = 3;
    localparam int NumDirs  = 4;

    typedef struct packed {
        logic [15:0] stick_min;
        logic [15:0] stick_max;
        logic [15:0] stick_center;
        logic [14:0] dead_band;
    } axis_cfg_t;

    typedef struct packed {
        logic [14:0] trigger_level;
        logic [14:0] release_level;
        logic [15:0] hold_repeat_ms;
    } dir_cfg_t;

    typedef struct packed {
        logic right;
        logic left;
        logic down;
        logic up;
    } dir_events_t;

endpackage

### rtl/jdd_axis_lane.sv
// One axis lane: deadzone mapping and a bit-serial restoring divider that
// yields a signed Q1.14 position. Depends on jdd_pkg.

module jdd_axis_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         raw,
    input  jdd_pkg::axis_cfg_t  cfg,
    output logic                done,
    output logic signed [15:0]  pos
);

    typedef enum logic [0:0] {
        LN_IDLE,
        LN_DIV
    } lane_state_t;

    lane_state_t                state_reg;
    logic [jdd_pkg::CntW-1:0]   cnt_reg;
    logic                       done_reg;
    logic                       zero_reg;
    logic                       neg_reg;
    logic                       sat_reg;
    logic [15:0]                rem_reg;
    logic [15:0]                div_reg;
    logic [jdd_pkg::QFrac-1:0]  quo_reg;

    logic signed [17:0] r18;
    logic signed [17:0] lo_edge;
    logic signed [17:0] hi_edge;
    logic signed [17:0] num;
    logic signed [17:0] span;
    logic               below;
    logic               above;
    logic               span_nonpos;
    logic               full;
    logic [16:0]        rem2;
    logic [16:0]        diff;
    logic               take;

    assign r18     = {2'b00, raw};
    assign lo_edge = $signed({2'b00, cfg.stick_center}) - $signed({3'b000, cfg.dead_band});
    assign hi_edge = $signed({2'b00, cfg.stick_center}) + $signed({3'b000, cfg.dead_band});
    assign below   = r18 < lo_edge;
    assign above   = r18 > hi_edge;

    always_comb
    begin
        if (below)
        begin
            num  = lo_edge - r18;
            span = lo_edge - $signed({2'b00, cfg.stick_min});
        end
        else
        begin
            num  = r18 - hi_edge;
            span = $signed({2'b00, cfg.stick_max}) - hi_edge;
        end
    end

    // A quotient of one or more means the distance reached the whole span.
    assign span_nonpos = span <= 18'sd0;
    assign full        = span_nonpos || (num >= span);

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, div_reg};
    assign take = rem2 >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                LN_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= LN_DIV;
                        cnt_reg   <= jdd_pkg::CntW'(jdd_pkg::DivSteps - 1);
                    end
                end
                LN_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= LN_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= LN_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == LN_IDLE && start)
        begin
            zero_reg <= !(below || above);
            neg_reg  <= below;
            sat_reg  <= full;
            rem_reg  <= num[15:0];
            div_reg  <= span[15:0];
            quo_reg  <= '0;
        end
        else if (state_reg == LN_DIV)
        begin
            rem_reg <= take ? diff[15:0] : rem2[15:0];
            quo_reg <= {quo_reg[jdd_pkg::QFrac-2:0], take};
        end
    end

    logic [15:0] mag;

    always_comb
    begin
        priority if (zero_reg)
            mag = '0;
        else if (sat_reg)
            mag = jdd_pkg::QOne;
        else
            mag = {{(16 - jdd_pkg::QFrac){1'b0}}, quo_reg};
    end

    assign pos  = neg_reg ? -$signed(mag) : $signed(mag);
    assign done = done_reg;

endmodule

### rtl/jdd_dir_merge.sv
// Merging stage: the four hysteresis machines with hold auto-repeat, fed by
// both axis lanes. Depends on jdd_pkg.

module jdd_dir_merge
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic [31:0]           now_ms,
    input  jdd_pkg::dir_cfg_t     cfg,
    output jdd_pkg::dir_events_t  events
);

    logic [jdd_pkg::NumDirs-1:0] held_reg;
    logic [jdd_pkg::NumDirs-1:0] held_next;
    logic [31:0]                 last_reg [jdd_pkg::NumDirs];
    logic [jdd_pkg::NumDirs-1:0] fire;

    logic signed [16:0] trig;
    logic signed [16:0] rel;

    assign trig = $signed({2'b00, cfg.trigger_level});
    assign rel  = $signed({2'b00, cfg.release_level});

    always_comb
    begin
        logic signed [16:0] p;
        logic               neg_side;
        logic               reached;
        logic               released;
        logic               press;
        logic [31:0]        elapsed;
        for (int d = 0; d < jdd_pkg::NumDirs; d++)
        begin
            p        = (d == jdd_pkg::DirUp || d == jdd_pkg::DirDown) ?
                       17'(pos_x) : 17'(pos_y);
            neg_side = (d == jdd_pkg::DirUp || d == jdd_pkg::DirLeft);
            reached  = neg_side ? (p <= -trig) : (p >= trig);
            released = neg_side ? (p > -rel) : (p < rel);
            press    = !held_reg[d] && reached;
            held_next[d] = held_reg[d] ? !released : reached;
            elapsed  = now_ms - last_reg[d];
            fire[d]  = press ||
                       (held_next[d] && (elapsed > {16'd0, cfg.hold_repeat_ms}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            for (int d = 0; d < jdd_pkg::NumDirs; d++)
            begin
                last_reg[d] <= '0;
            end
        end
        else if (update)
        begin
            held_reg <= held_next;
            for (int d = 0; d < jdd_pkg::NumDirs; d++)
            begin
                if (fire[d])
                begin
                    last_reg[d] <= now_ms;
                end
            end
        end
    end

    assign events.up    = fire[jdd_pkg::DirUp];
    assign events.down  = fire[jdd_pkg::DirDown];
    assign events.left  = fire[jdd_pkg::DirLeft];
    assign events.right = fire[jdd_pkg::DirRight];

endmodule

### rtl/joystick_direction_detector_core.sv
// Top level of the joystick direction detector: configuration registers,
// request sequencing and output register. Depends on jdd_pkg,
// jdd_axis_lane and jdd_dir_merge.

// One request carries an x and a y ADC reading and a millisecond timestamp.
// One result comes back with both Q1.14 positions and the four direction
// events. The two axes are normalized in parallel lanes. Each lane has a
// bit-serial divider that produces one quotient bit per cycle. The lanes load
// at the edge that accepts a request, run 14 divider steps and raise done;
// the merge state then writes the result into the output register once that
// register is free. A new request is accepted once the previous one has been
// merged into the output register. Because the result sits in an output
// register, the next request may start while that result waits to be taken.
// Configuration is written through the cfg channel, which is always ready.
// Writes to indexes beyond the register list are ignored.

module joystick_direction_detector_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream. s_tdata: raw_x [15:0], raw_y [31:16], now_ms [63:32]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // Output stream. m_tdata: pos_x [15:0], pos_y [31:16], up_event [32],
    // down_event [33], left_event [34], right_event [35], zero [39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [jdd_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [jdd_pkg::CfgDataW-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MERGE
    } core_state_t;

    core_state_t          state_reg;
    logic                 out_valid_reg;
    logic [39:0]          out_data_reg;
    logic [31:0]          now_reg;

    jdd_pkg::axis_cfg_t   axis_cfg_reg;
    jdd_pkg::dir_cfg_t    dir_cfg_reg;

    logic                 accept;
    logic                 out_free;
    logic                 merge_go;
    logic                 done_x;
    logic                 done_y;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    jdd_pkg::dir_events_t events;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign merge_go  = (state_reg == ST_MERGE) && out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_cfg_reg.stick_min     <= jdd_pkg::RstStickMin;
            axis_cfg_reg.stick_max     <= jdd_pkg::RstStickMax;
            axis_cfg_reg.stick_center  <= jdd_pkg::RstStickCenter;
            axis_cfg_reg.dead_band     <= jdd_pkg::RstDeadBand;
            dir_cfg_reg.trigger_level  <= jdd_pkg::RstTrigger;
            dir_cfg_reg.release_level  <= jdd_pkg::RstRelease;
            dir_cfg_reg.hold_repeat_ms <= jdd_pkg::RstHoldRepeat;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jdd_pkg::REG_STICK_MIN:      axis_cfg_reg.stick_min     <= cfg_data;
                jdd_pkg::REG_STICK_MAX:      axis_cfg_reg.stick_max     <= cfg_data;
                jdd_pkg::REG_STICK_CENTER:   axis_cfg_reg.stick_center  <= cfg_data;
                jdd_pkg::REG_DEAD_BAND:      axis_cfg_reg.dead_band     <= cfg_data[14:0];
                jdd_pkg::REG_TRIGGER_LEVEL:  dir_cfg_reg.trigger_level  <= cfg_data[14:0];
                jdd_pkg::REG_RELEASE_LEVEL:  dir_cfg_reg.release_level  <= cfg_data[14:0];
                jdd_pkg::REG_HOLD_REPEAT_MS: dir_cfg_reg.hold_repeat_ms <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    jdd_axis_lane u_lane_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .raw   (s_tdata[15:0]),
        .cfg   (axis_cfg_reg),
        .done  (done_x),
        .pos   (pos_x)
    );

    jdd_axis_lane u_lane_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .raw   (s_tdata[31:16]),
        .cfg   (axis_cfg_reg),
        .done  (done_y),
        .pos   (pos_y)
    );

    jdd_dir_merge u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (merge_go),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .now_ms (now_reg),
        .cfg    (dir_cfg_reg),
        .events (events)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= s_tdata[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= merge_go || (out_valid_reg && !m_tready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // Both lanes run the same fixed number of steps.
                    if (done_x && done_y)
                    begin
                        state_reg <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        out_data_reg  <= {4'b0000, events.right, events.left,
                                          events.down, events.up, pos_y, pos_x};
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/jdd_checker.sv
// Port-level checks for the joystick direction detector and the bind that
// attaches them to joystick_direction_detector_core. No other dependencies.

module jdd_port_checks
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // Only one request is in the lanes at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while lanes busy");

    // Positions never leave plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384) &&
                     ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                     ($signed(m_tdata[31:16]) >= -16'sd16384) &&
                     ($signed(m_tdata[31:16]) <= 16'sd16384))
    else $error("position out of range");

    // A request needs the full divider run, so no result directly follows one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind joystick_direction_detector_core jdd_port_checks u_jdd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/jdd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the joystick direction detector. It watches the sample, result
// and register-write channels, predicts every result and compares it field by field.
// Depends on jdd_pkg for the register indexes and the direction slots.

module jdd_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [63:0]                  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [39:0]                  m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [jdd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [jdd_pkg::CfgDataW-1:0] cfg_data,
    output int                           errors,
    output int                           pending,
    output int                           checked,
    output int                           fired
);
    import jdd_pkg::*;

    localparam int QUnit = 16384;

    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               up;
        logic               down;
        logic               left;
        logic               right;
    } joy_result_t;

    logic [15:0] stick_min_r;
    logic [15:0] stick_max_r;
    logic [15:0] stick_center_r;
    logic [14:0] dead_band_r;
    logic [14:0] trigger_r;
    logic [14:0] release_r;
    logic [15:0] hold_ms_r;
    logic        held_r [NumDirs];
    logic [31:0] last_fire_r [NumDirs];
    joy_result_t expected_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
        fired   = 0;
    end

    // Q1.14 position of one raw reading; edges are kept in full signed precision.
    function automatic logic signed [15:0] scale_axis(input logic [15:0] raw);
        longint r;
        longint lo_edge;
        longint hi_edge;
        longint span;
        longint q;
        r       = raw;
        lo_edge = longint'(stick_center_r) - longint'(dead_band_r);
        hi_edge = longint'(stick_center_r) + longint'(dead_band_r);
        q       = 0;
        if (r < lo_edge)
        begin
            span = lo_edge - longint'(stick_min_r);
            if (span <= 0)
                q = QUnit;
            else
                q = ((lo_edge - r) * QUnit) / span;
            if (q > QUnit)
                q = QUnit;
            q = -q;
        end
        else if (r > hi_edge)
        begin
            span = longint'(stick_max_r) - hi_edge;
            if (span <= 0)
                q = QUnit;
            else
                q = ((r - hi_edge) * QUnit) / span;
            if (q > QUnit)
                q = QUnit;
        end
        return 16'(q);
    endfunction

    // Hysteresis step of one direction: release first, otherwise a fresh press fires.
    task automatic track_direction(input int dir, input logic signed [15:0] pos,
                                   input bit toward_neg, input logic [31:0] now,
                                   output bit fire);
        int p;
        int trig;
        int rel;
        bit back_in;
        bit reached;
        p       = pos;
        trig    = trigger_r;
        rel     = release_r;
        back_in = toward_neg ? (p > -rel) : (p < rel);
        reached = toward_neg ? (p <= -trig) : (p >= trig);
        fire    = 1'b0;
        if (held_r[dir] && back_in)
            held_r[dir] = 1'b0;
        else if (!held_r[dir] && reached)
        begin
            held_r[dir]      = 1'b1;
            last_fire_r[dir] = now;
            fire             = 1'b1;
        end
    endtask

    task automatic predict_sample(input logic [63:0] d);
        joy_result_t      res;
        bit [NumDirs-1:0] ev;
        logic [31:0]      now;
        int               k;
        now       = d[63:32];
        res.pos_x = scale_axis(d[15:0]);
        res.pos_y = scale_axis(d[31:16]);
        track_direction(DirUp,    res.pos_x, 1'b1, now, ev[DirUp]);
        track_direction(DirDown,  res.pos_x, 1'b0, now, ev[DirDown]);
        track_direction(DirRight, res.pos_y, 1'b0, now, ev[DirRight]);
        track_direction(DirLeft,  res.pos_y, 1'b1, now, ev[DirLeft]);
        // Auto-repeat uses the wrapping time since the last event of each direction.
        for (k = 0; k < NumDirs; k++)
        begin
            if (held_r[k] && (now - last_fire_r[k]) > 32'(hold_ms_r))
            begin
                last_fire_r[k] = now;
                ev[k]          = 1'b1;
            end
        end
        res.up    = ev[DirUp];
        res.down  = ev[DirDown];
        res.left  = ev[DirLeft];
        res.right = ev[DirRight];
        fired += $countones(ev);
        expected_q.push_back(res);
    endtask

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic compare_result(input logic [39:0] d);
        joy_result_t want;
        if (expected_q.size() == 0)
        begin
            $error("result with no request outstanding: m_tdata=%h", d);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        check_field("pos_x",       want.pos_x, $signed(d[15:0]));
        check_field("pos_y",       want.pos_y, $signed(d[31:16]));
        check_field("up_event",    want.up,    d[32]);
        check_field("down_event",  want.down,  d[33]);
        check_field("left_event",  want.left,  d[34]);
        check_field("right_event", want.right, d[35]);
        check_field("pad",         0,          d[39:36]);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stick_min_r    = 16'd200;
            stick_max_r    = 16'd26000;
            stick_center_r = 16'd13100;
            dead_band_r    = 15'd2000;
            trigger_r      = 15'd14746;
            release_r      = 15'd6554;
            hold_ms_r      = 16'd500;
            for (int k = 0; k < NumDirs; k++)
            begin
                held_r[k]      = 1'b0;
                last_fire_r[k] = 32'd0;
            end
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STICK_MIN:      stick_min_r    = cfg_data;
                    REG_STICK_MAX:      stick_max_r    = cfg_data;
                    REG_STICK_CENTER:   stick_center_r = cfg_data;
                    REG_DEAD_BAND:      dead_band_r    = cfg_data[14:0];
                    REG_TRIGGER_LEVEL:  trigger_r      = cfg_data[14:0];
                    REG_RELEASE_LEVEL:  release_r      = cfg_data[14:0];
                    REG_HOLD_REPEAT_MS: hold_ms_r      = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_sample(s_tdata);
        end
        pending = expected_q.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the joystick direction detector bench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on jdd_pkg,
// joystick_direction_detector_core and jdd_checker.

module testbench;
    import jdd_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;  // outside the register list
    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 40;
    localparam int PhaseItems   = 130;

    // Where a stimulus reading is placed relative to the current calibration.
    typedef enum int {
        AT_REST,
        FULL_LOW,
        FULL_HIGH,
        PART_LOW,
        PART_HIGH,
        ANYWHERE
    } reach_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [39:0]         m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int fired;

    int          tx_idle       = 0;
    int          rx_idle       = 0;
    int          samples_sent  = 0;
    int          settings_used = 0;
    logic [31:0] now_ms        = 32'd0;
    int          cur_min       = 200;
    int          cur_max       = 26000;
    int          cur_center    = 13100;
    int          cur_dead      = 2000;
    int          cur_hold      = 500;

    joystick_direction_detector_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jdd_checker i_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .fired     (fired)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    // Leaves cfg_valid high so back-to-back writes keep it asserted.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_stick(input logic [15:0] lo, hi, mid, band, trig, rel, hold);
        write_reg(REG_STICK_MIN, lo);
        write_reg(REG_STICK_MAX, hi);
        write_reg(REG_STICK_CENTER, mid);
        write_reg(REG_DEAD_BAND, band);
        write_reg(REG_TRIGGER_LEVEL, trig);
        write_reg(REG_RELEASE_LEVEL, rel);
        write_reg(REG_HOLD_REPEAT_MS, hold);
        write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_min    = lo;
        cur_max    = hi;
        cur_center = mid;
        cur_dead   = band[14:0];
        cur_hold   = hold;
        settings_used++;
    endtask

    // Offers one sample request and returns once it is taken, sometimes after a random idle gap.
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [31:0] stamp);
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
        if ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_raw(input reach_t kind);
        int v;
        case (kind)
            AT_REST:   v = cur_center - cur_dead - 100 + $urandom_range(0, 2 * cur_dead + 200);
            FULL_LOW:  v = $urandom_range(0, cur_min + 300);
            FULL_HIGH: v = $urandom_range(cur_max < 300 ? 0 : cur_max - 300, 65535);
            PART_LOW:  v = $urandom_range(cur_min, cur_center);
            PART_HIGH: v = $urandom_range(cur_center, cur_max);
            default:   v = $urandom_range(0, 65535);
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Mostly small steps around the repeat interval, now and then a jump anywhere.
    function automatic logic [31:0] next_stamp();
        if ($urandom_range(49) == 0)
            now_ms = $urandom();
        else
            now_ms = now_ms + $urandom_range(0, cur_hold + cur_hold / 2 + 3);
        return now_ms;
    endfunction

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int     mode;
        int     ph;
        int     k;
        int     n;
        int     first;
        int     mn;
        int     mx;
        int     tr;
        reach_t kx;
        reach_t ky;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle = 11;
        rx_idle = 59;

        // Reset calibration: both deadzone edges sit 10900 counts from the range ends.
        send_sample(16'd13100, 16'd13100, 32'd1000);
        send_sample(16'd11100, 16'd15100, 32'd1010);
        send_sample(16'd11099, 16'd15101, 32'd1020);
        send_sample(16'd0,     16'd65535, 32'd1030);
        send_sample(16'd0,     16'd65535, 32'd1530);
        send_sample(16'd0,     16'd65535, 32'd1531);
        send_sample(16'd4560,  16'd21640, 32'd1540);
        send_sample(16'd13100, 16'd13100, 32'd1550);
        // Repeat timing across the timestamp wrap.
        send_sample(16'd65535, 16'd0,     32'hFFFF_FF00);
        send_sample(16'd65535, 16'd0,     32'h0000_00F4);
        send_sample(16'd65535, 16'd0,     32'h0000_00F5);
        send_sample(16'd13100, 16'd13100, 32'hFFFF_FFFF);
        settle();

        // Both spans negative: anything outside the deadzone saturates.
        program_stick(16'd20000, 16'd5000, 16'd13100, 16'd2000, 16'd14746, 16'd6554, 16'd500);
        send_sample(16'd11099, 16'd15101, 32'd2000);
        send_sample(16'd0,     16'd65535, 32'd2001);
        send_sample(16'd13100, 16'd13100, 32'd2002);
        settle();

        // Both spans exactly zero.
        program_stick(16'd11100, 16'd15100, 16'd13100, 16'd2000, 16'd14746, 16'd6554, 16'd500);
        send_sample(16'd11099, 16'd15101, 32'd3000);
        send_sample(16'd13100, 16'd13100, 32'd3001);
        settle();

        // Low edge below zero, trigger at exactly one, no repeat interval.
        // The dead band write carries bit 15, which the register drops.
        program_stick(16'd0, 16'd65535, 16'd100, 16'hFFFF, 16'd16384, 16'd16384, 16'd0);
        send_sample(16'd0,     16'd65535, 32'd4000);
        send_sample(16'd32867, 16'd65535, 32'd4001);
        send_sample(16'd32868, 16'd65535, 32'd4001);
        settle();

        // High edge past the top of the range and a trigger that cannot be reached.
        program_stick(16'd0, 16'd65535, 16'd65535, 16'd32767, 16'd20000, 16'h8064, 16'd10);
        send_sample(16'd65535, 16'd0,     32'd5000);
        send_sample(16'd32767, 16'd32768, 32'd5001);

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle = 11;
                    rx_idle = 59;
                end
                1:
                begin
                    tx_idle = 59;
                    rx_idle = 11;
                end
                default:
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            for (ph = 0; ph < 4; ph++)
            begin
                settle();
                k = mode * 4 + ph;
                if (k == 3)
                    program_stick('0, '0, '0, '0, '0, '0, '0);
                else if (k == 7)
                    program_stick('1, '1, '1, '1, '1, '1, '1);
                else if (k == 11)
                    program_stick(16'd200, 16'd26000, 16'd13100, 16'd2000,
                                  16'd14746, 16'd6554, 16'd500);
                else if (k % 4 == 1)
                    program_stick(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom_range(0, 600)));
                else
                begin
                    mn = $urandom_range(0, 3000);
                    mx = $urandom_range(20000, 65535);
                    tr = $urandom_range(3000, 16384);
                    program_stick(16'(mn), 16'(mx),
                                  16'((mn + mx) / 2 + $urandom_range(0, 2000) - 1000),
                                  16'($urandom_range(0, 4000)), 16'(tr),
                                  16'($urandom_range(0, tr)), 16'($urandom_range(0, 400)));
                end

                first = samples_sent;
                while (samples_sent - first < PhaseItems)
                begin
                    n = $urandom_range(1, 8);
                    if ($urandom_range(9) < 2)
                    begin
                        repeat (n)
                            send_sample(16'($urandom), 16'($urandom), next_stamp());
                    end
                    else
                    begin
                        // A stroke: deflect, hold for a while, then let go.
                        kx = reach_t'($urandom_range(0, int'(PART_HIGH)));
                        ky = reach_t'($urandom_range(0, int'(PART_HIGH)));
                        repeat (n)
                            send_sample(pick_raw(kx), pick_raw(ky), next_stamp());
                        repeat ($urandom_range(1, 3))
                            send_sample(pick_raw(AT_REST), pick_raw(AT_REST), next_stamp());
                    end
                end
            end
        end
        settle();

        $display("Sent %0d samples under %0d register settings; %0d results checked.",
                 samples_sent, settings_used, checked);
        $display("Stick presses and repeats seen: %0d, with saturation, spans and wrap.",
                 fired);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
